// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/pdsum_pkg.sv -----
// package with widths, types and control structs of the divisor sum block
`timescale 1ns / 1ps
`default_nettype none

package pdsum_pkg;

    localparam int NUMBER_BITS = 20;
    localparam int SUM_BITS    = 22;
    localparam int S_BITS      = (NUMBER_BITS + 1) / 2;
    localparam int ROOT_BITS   = S_BITS + 1;
    localparam int PROD_BITS   = 2 * S_BITS;
    localparam int CNT_BITS    = $clog2(NUMBER_BITS);
    localparam int ACC_BITS    = ((NUMBER_BITS > SUM_BITS) ? NUMBER_BITS : SUM_BITS) + 2;

    typedef logic [NUMBER_BITS-1:0] t_number;
    typedef logic [SUM_BITS-1:0]    t_sum;
    typedef logic [S_BITS-1:0]      t_sroot;
    typedef logic [ROOT_BITS-1:0]   t_root;
    typedef logic [CNT_BITS-1:0]    t_cnt;

    localparam t_sum SUM_MAX = '1;

    typedef struct packed {
        logic load_in;
        logic sqrt_step;
        logic root_fix;
        logic div_start;
        logic div_step;
        logic acc;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cont;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hdl/pdsum_ctrl.sv -----
// controller state machine sequencing root, trial divisions and result
`timescale 1ns / 1ps
`default_nettype none

module pdsum_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  pdsum_pkg::t_dp_sts  i_sts,
    output pdsum_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROOT = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_TEST = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.root_fix = 1'b1;
                n_state        = S_TEST;
            end
            S_TEST: begin
                if (i_sts.cont) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_TEST;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/pdsum_dp.sv -----
// datapath: bitwise square root, restoring divider, accumulator, output register
`timescale 1ns / 1ps
`default_nettype none

module pdsum_dp (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  pdsum_pkg::t_dp_cmd            i_cmd,
    output pdsum_pkg::t_dp_sts            o_sts,
    input  wire [pdsum_pkg::NUMBER_BITS-1:0] i_number,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [pdsum_pkg::SUM_BITS-1:0] o_divisor_sum
);

    pdsum_pkg::t_number r_n;
    pdsum_pkg::t_sroot  r_s;
    pdsum_pkg::t_cnt    r_cnt;
    pdsum_pkg::t_root   r_r;
    pdsum_pkg::t_root   r_i;
    pdsum_pkg::t_root   r_rem;
    pdsum_pkg::t_number r_quo;
    pdsum_pkg::t_sum    r_acc;
    pdsum_pkg::t_sum    r_out_sum;
    logic               r_out_valid;

    pdsum_pkg::t_sroot                   w_trial;
    pdsum_pkg::t_sroot                   w_mul_op;
    logic [pdsum_pkg::PROD_BITS-1:0]     w_prod;
    logic [pdsum_pkg::PROD_BITS-1:0]     w_n_ext;
    pdsum_pkg::t_root                    w_root;
    logic [pdsum_pkg::ROOT_BITS:0]       w_rem_sh;
    logic [pdsum_pkg::ROOT_BITS:0]       w_div;
    logic                                w_ge;
    logic [pdsum_pkg::ROOT_BITS:0]       w_rem_nx;
    logic                                w_hit;
    logic [pdsum_pkg::ACC_BITS-1:0]      w_sum_wide;
    pdsum_pkg::t_sum                     w_sum_sat;

    assign w_trial  = r_s | (pdsum_pkg::S_BITS'(1) << r_cnt);
    assign w_mul_op = i_cmd.root_fix ? r_s : w_trial;
    assign w_prod   = pdsum_pkg::PROD_BITS'(w_mul_op) * pdsum_pkg::PROD_BITS'(w_mul_op);
    assign w_n_ext  = pdsum_pkg::PROD_BITS'(r_n);
    assign w_root   = (w_prod == w_n_ext) ? pdsum_pkg::ROOT_BITS'(r_s)
                                          : pdsum_pkg::ROOT_BITS'(r_s) + pdsum_pkg::ROOT_BITS'(1);

    assign w_rem_sh = {r_rem, r_quo[pdsum_pkg::NUMBER_BITS-1]};
    assign w_div    = {1'b0, r_i};
    assign w_ge     = (w_rem_sh >= w_div);
    assign w_rem_nx = w_ge ? (w_rem_sh - w_div) : w_rem_sh;

    assign w_hit      = (r_rem == '0);
    assign w_sum_wide = pdsum_pkg::ACC_BITS'(r_acc)
                      + (w_hit ? pdsum_pkg::ACC_BITS'(r_i) : '0)
                      + ((w_hit && (pdsum_pkg::ACC_BITS'(r_quo) > pdsum_pkg::ACC_BITS'(r_r)))
                         ? pdsum_pkg::ACC_BITS'(r_quo) : '0);
    assign w_sum_sat  = (w_sum_wide > pdsum_pkg::ACC_BITS'(pdsum_pkg::SUM_MAX))
                      ? pdsum_pkg::SUM_MAX : w_sum_wide[pdsum_pkg::SUM_BITS-1:0];

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cont     = (r_i > pdsum_pkg::ROOT_BITS'(1))
                         && (pdsum_pkg::NUMBER_BITS'(r_i) != r_n);
    assign o_sts.out_busy = r_out_valid & ~i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_n   <= i_number;
            r_s   <= '0;
            r_cnt <= pdsum_pkg::CNT_BITS'(pdsum_pkg::S_BITS - 1);
            r_acc <= pdsum_pkg::SUM_BITS'(1);
        end
        if (i_cmd.sqrt_step) begin
            if (w_prod <= w_n_ext) begin
                r_s <= w_trial;
            end
            r_cnt <= r_cnt - pdsum_pkg::CNT_BITS'(1);
        end
        if (i_cmd.root_fix) begin
            r_r <= w_root;
            r_i <= w_root;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_n;
            r_cnt <= pdsum_pkg::CNT_BITS'(pdsum_pkg::NUMBER_BITS - 1);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem_nx[pdsum_pkg::ROOT_BITS-1:0];
            r_quo <= {r_quo[pdsum_pkg::NUMBER_BITS-2:0], w_ge};
            r_cnt <= r_cnt - pdsum_pkg::CNT_BITS'(1);
        end
        if (i_cmd.acc) begin
            r_acc <= w_sum_sat;
            r_i   <= r_i - pdsum_pkg::ROOT_BITS'(1);
        end
        if (i_cmd.load_out) begin
            r_out_sum <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_divisor_sum = r_out_sum;

endmodule

`default_nettype wire

// ----- hdl/proper_divisor_sum.sv -----
// top level: sum of proper divisors by trial division
//
//  channel   signals                              width
//  input     i_in_valid  o_in_ready   i_number     20
//  output    o_out_valid i_out_ready  o_divisor_sum 22
//
// each candidate divisor, from r the ceiling root of the number down, is tested by
//   restoring division, one divider step per cycle (20 steps plus test and add per candidate)
// the root takes one multiply and compare per bit
// reset clears the controller and the output valid flag
// a new number is taken while a result waits; it finishes only once the output is free
`timescale 1ns / 1ps
`default_nettype none

module proper_divisor_sum (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire [pdsum_pkg::NUMBER_BITS-1:0] i_number,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [pdsum_pkg::SUM_BITS-1:0]  o_divisor_sum
);

    pdsum_pkg::t_dp_cmd w_cmd;
    pdsum_pkg::t_dp_sts w_sts;

    pdsum_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pdsum_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_number      (i_number),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_divisor_sum (o_divisor_sum)
    );

endmodule

`default_nettype wire

// ----- hdl/pdsum_checker.sv -----
// port-level checker for the divisor sum block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pdsum_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              o_in_ready,
    input wire [pdsum_pkg::NUMBER_BITS-1:0] i_number,
    input wire                              o_out_valid,
    input wire                              i_out_ready,
    input wire [pdsum_pkg::SUM_BITS-1:0]    o_divisor_sum
);

    // stalled result keeps valid
    `ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    // stalled result keeps its value
    `ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_divisor_sum))
    // after an input transfer the block is busy
    `ASSERT_NEXT(a_busy, i_in_valid && o_in_ready, !o_in_ready)
    // the sum always counts the divisor one
    `ASSERT_SAME(a_nonzero, o_out_valid, o_divisor_sum != '0)

endmodule

bind proper_divisor_sum pdsum_checker u_pdsum_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_number      (i_number),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_divisor_sum (o_divisor_sum)
);

`default_nettype wire

// ----- verif/proper_divisor_sum_test.sv -----
// testbench for proper_divisor_sum: directed and random numbers against a trial-division predictor
`timescale 1ns / 1ps

module proper_divisor_sum_test;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int IDLE_PERCENT   = 29;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    pdsum_pkg::t_number i_number = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    pdsum_pkg::t_sum    o_divisor_sum;

    pdsum_pkg::t_sum    sum_queue[$];
    int                 fail_count = 0;
    int                 stall_cycles = 0;
    bit                 steady_flow = 1'b0;

    proper_divisor_sum uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_number      (i_number),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_divisor_sum (o_divisor_sum)
    );

    always #5 i_clk = ~i_clk;

    function automatic pdsum_pkg::t_sum divisor_sum_of(input pdsum_pkg::t_number n);
        longint unsigned v, s, t, r, total, i, j;
        int b;
        v = n;
        s = 0;
        for (b = 15; b >= 0; b--) begin
            t = s | (64'd1 << b);
            if (t * t <= v) begin
                s = t;
            end
        end
        r = (s * s == v) ? s : s + 1;
        total = 1;
        for (i = r; i > 1 && i != v; i--) begin
            if (v % i == 0) begin
                j = v / i;
                total += i;
                if (j > r) begin
                    total += j;
                end
            end
        end
        if (total > pdsum_pkg::SUM_MAX) begin
            total = pdsum_pkg::SUM_MAX;
        end
        return pdsum_pkg::t_sum'(total);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_number(input pdsum_pkg::t_number n);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_number   <= n;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sum_queue.push_back(divisor_sum_of(n));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sum_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic pdsum_pkg::t_number random_number();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            return pdsum_pkg::t_number'($urandom_range(15));
        end else if (pick < 90) begin
            return pdsum_pkg::t_number'($urandom_range(4095));
        end
        return pdsum_pkg::t_number'($urandom);
    endfunction

    task automatic test_small_inputs();
        pdsum_pkg::t_number n;
        for (int k = 0; k <= 6; k++) begin
            n = pdsum_pkg::t_number'(k);
            send_number(n);
        end
    endtask

    task automatic test_special_values();
        pdsum_pkg::t_number vals[14];
        vals = '{9, 16, 25, 28, 496, 8128, 997, 65536, 524288, 720720,
                 1000000, 1046529, 1048574, 1048575};
        foreach (vals[k]) begin
            send_number(vals[k]);
        end
    endtask

    task automatic test_random_idle(input int count);
        steady_flow = 1'b0;
        repeat (count) send_number(random_number());
    endtask

    task automatic test_drain_pause(input int count);
        steady_flow = 1'b0;
        repeat (count) send_number(random_number());
        i_in_valid <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        repeat (count) send_number(random_number());
    endtask

    task automatic test_back_to_back(input int count);
        steady_flow = 1'b1;
        repeat (count) send_number(random_number());
        steady_flow = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (steady_flow) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        pdsum_pkg::t_sum want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sum_queue.size() == 0) begin
                $error("unexpected transfer: divisor_sum actual %0d", o_divisor_sum);
                fail_count++;
            end else begin
                want = sum_queue.pop_front();
                if (o_divisor_sum !== want) begin
                    $error("divisor_sum mismatch: expected %0d actual %0d",
                           want, o_divisor_sum);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_small_inputs();
        test_special_values();
        test_random_idle(20);
        test_drain_pause(10);
        test_back_to_back(30);
        test_random_idle(15);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && sum_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
